/* hdl/kabt_pkg.sv */
// ----------------------------------------------------------------------------
// kabt_pkg
// Shared types and constants for the key/action binding table.
// ----------------------------------------------------------------------------
package kabt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int MAP_LIMIT_DEF   = 8;
    localparam int KEY_BITS        = 9;
    localparam int ACTION_BITS     = 8;
    localparam int QUEUE_DEPTH     = 2;

    typedef struct packed {
        logic [3:0]             operation;
        logic [KEY_BITS-1:0]    key_code;
        logic [ACTION_BITS-1:0] action_id;
        logic                   is_repeat;
    } t_in_item;

    typedef struct packed {
        logic [ACTION_BITS-1:0] mapped_action;
        logic                   pressed;
        logic [KEY_BITS-1:0]    found_key;
        logic                   status;
        logic                   last_result;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_CLEAR    = 3'd0,
        OP_LOAD     = 3'd1,
        OP_ADD      = 3'd2,
        OP_REM_KEY  = 3'd3,
        OP_REM_ACT  = 3'd4,
        OP_GET_KEY  = 3'd5,
        OP_KEY_DOWN = 3'd6,
        OP_KEY_UP   = 3'd7
    } t_op;

    // raw operation code for key events and the first code that means nothing
    localparam logic [3:0] CODE_KEY_DOWN = 4'd6;
    localparam logic [3:0] CODE_KEY_UP   = 4'd7;
    localparam logic [3:0] CODE_OTHER    = 4'd8;

    typedef struct packed {
        t_op                    op;
        logic [KEY_BITS-1:0]    key;
        logic [ACTION_BITS-1:0] act;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MV_RD,
        ST_MV_WR,
        ST_EMIT,
        ST_FLUSH
    } t_state;

endpackage

/* hdl/kabt_fifo.sv */
// ----------------------------------------------------------------------------
// kabt_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module kabt_fifo #(
    parameter type T = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  T     i_data,
    output logic o_full,
    input  logic i_rd,
    output T     o_data,
    output logic o_empty
);
    import kabt_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    T              r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_wr, w_rd;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (w_rd) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

/* hdl/kabt_front.sv */
// ----------------------------------------------------------------------------
// kabt_front
// Accepts input items, drops those that give no result, queues commands.
// ----------------------------------------------------------------------------
module kabt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  kabt_pkg::t_in_item i_item,
    output logic              o_full,
    input  logic              i_cmd_pop,
    output kabt_pkg::t_cmd    o_cmd,
    output logic              o_cmd_empty
);
    import kabt_pkg::*;

    logic w_keep, w_wr;
    t_cmd w_cmd;

    // repeated key events and unknown codes are taken but never reach the back end
    always_comb begin
        w_keep = (i_item.operation < CODE_OTHER);
        if ((i_item.operation == CODE_KEY_DOWN || i_item.operation == CODE_KEY_UP)
            && i_item.is_repeat) begin
            w_keep = 1'b0;
        end
        w_cmd.op  = t_op'(i_item.operation[2:0]);
        w_cmd.key = i_item.key_code;
        w_cmd.act = i_item.action_id;
    end

    assign w_wr = i_push && w_keep;

    kabt_fifo #(.T(t_cmd)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_rd    (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (o_cmd_empty)
    );

endmodule

/* hdl/kabt_exec.sv */
// ----------------------------------------------------------------------------
// kabt_exec
// Table storage and the scan sequencer that carries out each command.
// ----------------------------------------------------------------------------
module kabt_exec #(
    parameter int TABLE_DEPTH = kabt_pkg::TABLE_DEPTH_DEF,
    parameter int MAP_LIMIT   = kabt_pkg::MAP_LIMIT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kabt_pkg::t_cmd      i_cmd,
    input  logic                i_cmd_empty,
    output logic                o_cmd_pop,
    output kabt_pkg::t_out_item o_res,
    output logic                o_res_push,
    input  logic                i_res_full
);
    import kabt_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(MAP_LIMIT + 1);

    logic [KEY_BITS-1:0]    r_key_mem [TABLE_DEPTH];
    logic [ACTION_BITS-1:0] r_act_mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0]    r_rd_key;
    logic [ACTION_BITS-1:0] r_rd_act;

    t_state                 r_state, n_state;
    t_cmd                   r_cmd, n_cmd;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [CW-1:0]          r_idx, n_idx;
    logic                   r_cv, n_cv;
    logic [IW-1:0]          r_ci, n_ci;
    logic [IW-1:0]          r_tgt, n_tgt;
    logic                   r_pend, n_pend;
    logic [ACTION_BITS-1:0] r_pact, n_pact;
    logic [NW-1:0]          r_n, n_n;
    logic [KEY_BITS-1:0]    r_fk, n_fk;
    logic                   r_st, n_st;

    logic                   w_rd_en, w_key_we, w_act_we;
    logic [IW-1:0]          w_rd_addr, w_wr_addr;
    logic [KEY_BITS-1:0]    w_wr_key;
    logic [ACTION_BITS-1:0] w_wr_act;
    logic [CW-1:0]          w_dec, w_last;
    logic                   w_fwd, w_issue, w_hit, w_keyev, w_stall, w_lim, w_pressed;

    assign w_dec     = r_idx - CW'(1);
    assign w_last    = r_cnt - CW'(1);
    assign w_fwd     = (r_cmd.op != OP_REM_ACT);
    assign w_issue   = w_fwd ? (r_idx < r_cnt) : (r_idx != '0);
    assign w_keyev   = (r_cmd.op == OP_KEY_DOWN) || (r_cmd.op == OP_KEY_UP);
    assign w_hit     = r_cv && ((r_cmd.op == OP_GET_KEY || r_cmd.op == OP_REM_ACT)
                                ? (r_rd_act == r_cmd.act) : (r_rd_key == r_cmd.key));
    assign w_stall   = (r_state == ST_SCAN) && w_hit && w_keyev && r_pend && i_res_full;
    assign w_lim     = ((r_n + NW'(1)) == NW'(MAP_LIMIT));
    assign w_pressed = (r_cmd.op == OP_KEY_DOWN);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    if (i_cmd.op inside {OP_CLEAR, OP_LOAD}) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!w_stall) begin
                    if (w_hit) begin
                        if (r_cmd.op inside {OP_ADD, OP_GET_KEY}) begin
                            n_state = ST_EMIT;
                        end else if (r_cmd.op inside {OP_REM_KEY, OP_REM_ACT}) begin
                            n_state = ST_MV_RD;
                        end else if (w_lim) begin
                            n_state = ST_FLUSH;
                        end
                    end else if (!w_issue && !r_cv) begin
                        if (w_keyev) begin
                            n_state = r_pend ? ST_FLUSH : ST_IDLE;
                        end else begin
                            n_state = ST_EMIT;
                        end
                    end
                end
            end
            ST_MV_RD: n_state = ST_MV_WR;
            ST_MV_WR: n_state = (r_cmd.op == OP_REM_ACT) ? ST_SCAN : ST_EMIT;
            ST_EMIT, ST_FLUSH: begin
                if (!i_res_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and strobes
    always_comb begin
        n_cmd      = r_cmd;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_cv       = r_cv;
        n_ci       = r_ci;
        n_tgt      = r_tgt;
        n_pend     = r_pend;
        n_pact     = r_pact;
        n_n        = r_n;
        n_fk       = r_fk;
        n_st       = r_st;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        w_rd_en    = 1'b0;
        w_rd_addr  = r_idx[IW-1:0];
        w_key_we   = 1'b0;
        w_act_we   = 1'b0;
        w_wr_addr  = r_cnt[IW-1:0];
        w_wr_key   = i_cmd.key;
        w_wr_act   = i_cmd.act;
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_st      = 1'b0;
                    n_fk      = '0;
                    n_pend    = 1'b0;
                    n_n       = '0;
                    n_cv      = 1'b0;
                    n_idx     = (i_cmd.op == OP_REM_ACT) ? r_cnt : '0;
                    if (i_cmd.op == OP_CLEAR) begin
                        n_cnt = '0;
                    end else if (i_cmd.op == OP_LOAD) begin
                        if (r_cnt == CW'(TABLE_DEPTH)) begin
                            n_st = 1'b1;
                        end else begin
                            w_key_we = 1'b1;
                            w_act_we = 1'b1;
                            n_cnt    = r_cnt + CW'(1);
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (!w_stall) begin
                    if (w_hit && !w_keyev) begin
                        n_tgt = r_ci;
                        if (r_cmd.op == OP_ADD) begin
                            w_act_we  = 1'b1;
                            w_wr_addr = r_ci;
                            w_wr_act  = r_cmd.act;
                        end else if (r_cmd.op == OP_GET_KEY) begin
                            n_fk = r_rd_key;
                        end
                    end else if (!w_hit && !w_issue && !r_cv) begin
                        // scan done without a match: add appends
                        if (r_cmd.op == OP_ADD) begin
                            w_wr_key = r_cmd.key;
                            w_wr_act = r_cmd.act;
                            if (r_cnt == CW'(TABLE_DEPTH)) begin
                                n_st = 1'b1;
                            end else begin
                                w_key_we = 1'b1;
                                w_act_we = 1'b1;
                                n_cnt    = r_cnt + CW'(1);
                            end
                        end
                    end else begin
                        if (w_hit) begin
                            // key event match: previous one is not the last
                            if (r_pend) begin
                                o_res_push          = 1'b1;
                                o_res.mapped_action = r_pact;
                                o_res.pressed       = w_pressed;
                            end
                            n_pend = 1'b1;
                            n_pact = r_rd_act;
                            n_n    = r_n + NW'(1);
                        end
                        n_cv = w_issue;
                        if (w_issue) begin
                            w_rd_en = 1'b1;
                            if (w_fwd) begin
                                w_rd_addr = r_idx[IW-1:0];
                                n_idx     = r_idx + CW'(1);
                            end else begin
                                w_rd_addr = w_dec[IW-1:0];
                                n_idx     = w_dec;
                            end
                            n_ci = w_rd_addr;
                        end
                    end
                end
            end
            ST_MV_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_last[IW-1:0];
            end
            ST_MV_WR: begin
                w_key_we  = 1'b1;
                w_act_we  = 1'b1;
                w_wr_addr = r_tgt;
                w_wr_key  = r_rd_key;
                w_wr_act  = r_rd_act;
                n_cnt     = w_last;
                n_idx     = CW'(r_tgt);
                n_cv      = 1'b0;
            end
            ST_EMIT: begin
                o_res_push        = !i_res_full;
                o_res.found_key   = r_fk;
                o_res.status      = r_st;
                o_res.last_result = 1'b1;
            end
            ST_FLUSH: begin
                o_res_push          = !i_res_full;
                o_res.mapped_action = r_pact;
                o_res.pressed       = w_pressed;
                o_res.last_result   = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            r_key_mem[w_wr_addr] <= w_wr_key;
        end
        if (w_act_we) begin
            r_act_mem[w_wr_addr] <= w_wr_act;
        end
        if (w_rd_en) begin
            r_rd_key <= r_key_mem[w_rd_addr];
            r_rd_act <= r_act_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_idx  <= n_idx;
        r_ci   <= n_ci;
        r_tgt  <= n_tgt;
        r_pact <= n_pact;
        r_n    <= n_n;
        r_fk   <= n_fk;
        r_st   <= n_st;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_cv    <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_cv    <= n_cv;
            r_pend  <= n_pend;
        end
    end

endmodule

/* hdl/key_action_binding_table.sv */
// ----------------------------------------------------------------------------
// key_action_binding_table
// Ordered key/action table: load, add, remove, reverse lookup, key events.
//
// channel  direction  handshake          payload
// item     in         push / full        i_item  (kabt_pkg::t_in_item)
// result   out        pop / empty        o_result (kabt_pkg::t_out_item)
//
// Clear and load go straight to their result without a scan. Every other
// command scans the stored entries through one registered read port, one
// entry per cycle unless a result push is held by a full result queue; a
// remove moves the last entry into the freed slot. Results are queued, so a
// stalled pop only halts the scan once the result queue is full. Reset clears
// the count and the queues; stored entries are not cleared.
// ----------------------------------------------------------------------------
module key_action_binding_table #(
    parameter int TABLE_DEPTH = kabt_pkg::TABLE_DEPTH_DEF,
    parameter int MAP_LIMIT   = kabt_pkg::MAP_LIMIT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    input  kabt_pkg::t_in_item  i_item,
    output logic                full,
    input  logic                pop,
    output kabt_pkg::t_out_item o_result,
    output logic                empty
);
    import kabt_pkg::*;

    t_cmd      w_cmd;
    logic      w_cmd_empty, w_cmd_pop;
    t_out_item w_res;
    logic      w_res_push, w_res_full;

    kabt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push && !full),
        .i_item      (i_item),
        .o_full      (full),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd       (w_cmd),
        .o_cmd_empty (w_cmd_empty)
    );

    kabt_exec #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAP_LIMIT   (MAP_LIMIT)
    ) u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .o_res       (w_res),
        .o_res_push  (w_res_push),
        .i_res_full  (w_res_full)
    );

    kabt_fifo #(.T(t_out_item)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_rd    (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

`ifndef SYNTHESIS
    a_res_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_res_push && w_res_full))
        else $error("result pushed into full queue");

    a_cmd_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd_pop && w_cmd_empty))
        else $error("command taken from empty queue");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");
`endif

endmodule
